>>> rtl/core/wws_pkg.sv
// wws_pkg: shared constants, output selector codes and the command and status
// structs that join the whole-word substituter controller and datapath
// no dependencies
package wws_pkg;

   localparam int MAX_WORD_DEFAULT = 8;

   localparam int CHAR_W   = 8;
   localparam int WORD_W   = 64;
   localparam int LEN_W    = 4;
   localparam int CSR_IDX_W = 8;
   localparam int REP_MAX  = 8;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WORD        = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LENGTH      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_WORD   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 8'd3;

   localparam logic [1:0] OUT_REQ  = 2'd0;
   localparam logic [1:0] OUT_WORD = 2'd1;
   localparam logic [1:0] OUT_HOLD = 2'd2;

   typedef struct packed {
      logic       load_out;
      logic [1:0] out_sel;
      logic       out_last;
      logic       store_letter;
      logic       start_flush;
      logic       flush_replace;
      logic       step_idx;
      logic       clear_count;
      logic       set_pass;
      logic       clear_pass;
   } wws_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_letter;
      logic pass;
      logic full;
      logic empty;
      logic match;
      logic rep_zero;
      logic last;
   } wws_status_type;

endpackage

>>> rtl/core/wws_ctrl.sv
// wws_ctrl: controller state machine of the whole-word substituter
// depends on wws_pkg; drives wws_datapath through wws_cmd_type
module wws_ctrl
   import wws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  wws_status_type status,
   output wws_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_TAIL = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_letter) begin
                  if (status.pass) begin
                     cmd.load_out = 1'b1;
                     cmd.out_sel  = OUT_REQ;
                     cmd.out_last = 1'b1;
                  end else if (!status.full) begin
                     cmd.store_letter = 1'b1;
                  end else begin
                     cmd.start_flush = 1'b1;
                     cmd.set_pass    = 1'b1;
                     state_in        = ST_EMIT;
                  end
               end else begin
                  if (status.pass || status.empty || (status.match && status.rep_zero)) begin
                     cmd.load_out    = 1'b1;
                     cmd.out_sel     = OUT_REQ;
                     cmd.out_last    = 1'b1;
                     cmd.clear_pass  = 1'b1;
                     cmd.clear_count = 1'b1;
                  end else begin
                     cmd.start_flush   = 1'b1;
                     cmd.flush_replace = status.match;
                     state_in          = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_WORD;
               cmd.step_idx = 1'b1;
               if (status.last) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.load_out    = 1'b1;
               cmd.out_sel     = OUT_HOLD;
               cmd.out_last    = 1'b1;
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/wws_datapath.sv
// wws_datapath: word buffer, counters, configuration registers, match logic
// and the result output register of the whole-word substituter
// depends on wws_pkg; commanded by wws_ctrl
module wws_datapath
   import wws_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CHAR_W-1:0]    req_char_in,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [CHAR_W-1:0]    rsp_char_out,
   output logic                 rsp_from_replacement,
   output logic                 rsp_run_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   input  wws_cmd_type          cmd,
   output wws_status_type       status
);

   localparam int CNT_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int EMIT_W = $clog2(REP_MAX);

   logic [CHAR_W-1:0] store_ff [MAX_WORD];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              pass_ff;
   logic              pass_in;
   logic [WORD_W-1:0] target_word_ff;
   logic [LEN_W-1:0]  target_len_ff;
   logic [WORD_W-1:0] rep_word_ff;
   logic [LEN_W-1:0]  rep_len_ff;
   logic [CHAR_W-1:0] hold_ff;
   logic              replace_ff;
   logic [EMIT_W-1:0] idx_ff;
   logic [EMIT_W-1:0] idx_in;
   logic [EMIT_W-1:0] n_last_ff;
   logic [EMIT_W-1:0] n_last_in;
   logic [LEN_W-1:0]  rep_len_eff;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] char_out_ff;
   logic              from_rep_ff;
   logic              run_end_ff;
   logic [CHAR_W-1:0] word_byte;
   logic [CHAR_W-1:0] out_byte;
   logic              bytes_equal;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_word_ff <= '0;
         target_len_ff  <= LEN_W'(1);
         rep_word_ff    <= '0;
         rep_len_ff     <= LEN_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_WORD:        target_word_ff <= csr_data;
            CSR_TARGET_LENGTH:      target_len_ff  <= csr_data[LEN_W-1:0];
            CSR_REPLACEMENT_WORD:   rep_word_ff    <= csr_data;
            CSR_REPLACEMENT_LENGTH: rep_len_ff     <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // status
   always_comb begin
      status.is_letter = (req_char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
                      || (req_char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]});
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      status.pass      = pass_ff;
      status.full      = (count_ff == CNT_W'(MAX_WORD));
      status.empty     = (count_ff == '0);
      status.rep_zero  = (rep_len_ff == '0);
      status.last      = (idx_ff == n_last_ff);
      bytes_equal      = 1'b1;
      for (int i = 0; i < MAX_WORD; i++) begin
         if ((CNT_W'(i) < count_ff)
               && (store_ff[i] != target_word_ff[8*i +: 8])) begin
            bytes_equal = 1'b0;
         end
      end
      status.match = !status.empty && (LEN_W'(count_ff) == target_len_ff) && bytes_equal;
   end

   assign rep_len_eff = (rep_len_ff > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX) : rep_len_ff;

   always_comb begin
      count_in  = count_ff;
      pass_in   = pass_ff;
      idx_in    = idx_ff;
      n_last_in = n_last_ff;
      if (cmd.store_letter) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.set_pass) begin
         pass_in = 1'b1;
      end
      if (cmd.clear_pass) begin
         pass_in = 1'b0;
      end
      if (cmd.start_flush) begin
         idx_in = '0;
         if (cmd.flush_replace) begin
            n_last_in = EMIT_W'(rep_len_eff - 1'b1);
         end else begin
            n_last_in = EMIT_W'(count_ff - 1'b1);
         end
      end
      if (cmd.step_idx) begin
         idx_in = EMIT_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pass_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pass_ff  <= pass_in;
      end
   end

   // word buffer and flush bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.store_letter) begin
         store_ff[count_ff[IDX_W-1:0]] <= req_char_in;
      end
      if (cmd.start_flush) begin
         hold_ff    <= req_char_in;
         replace_ff <= cmd.flush_replace;
      end
      idx_ff    <= idx_in;
      n_last_ff <= n_last_in;
   end

   // output register
   always_comb begin
      if (replace_ff) begin
         word_byte = rep_word_ff[8*idx_ff +: 8];
      end else begin
         word_byte = store_ff[idx_ff[IDX_W-1:0]];
      end
      case (cmd.out_sel)
         OUT_WORD: out_byte = word_byte;
         OUT_HOLD: out_byte = hold_ff;
         default:  out_byte = req_char_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         char_out_ff <= out_byte;
         from_rep_ff <= (cmd.out_sel == OUT_WORD) && replace_ff;
         run_end_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_char_out         = char_out_ff;
   assign rsp_from_replacement = from_rep_ff;
   assign rsp_run_end          = run_end_ff;

endmodule

>>> rtl/core/whole_word_substituter_unit.sv
// whole_word_substituter_unit: top level of the whole-word find and replace block
// depends on wws_pkg, wws_ctrl and wws_datapath
//
// usage
//   req channel: one text byte per transfer on req_char_in, taken when req_valid
//   is high and req_stall low; letters are buffered, any other byte ends a word
//   rsp channel: output bytes with from_replacement and run_end flags, taken
//   when rsp_valid is high and rsp_stall low; run_end marks the last byte
//   produced by one input byte
//   csr channel: index and 64-bit data, always ready; 0 target word,
//   1 target length, 2 replacement word, 3 replacement length
// timing
//   a buffered letter produces nothing
//   a byte that ends a word of n letters, or a letter arriving on a full buffer,
//   flushes the word (replacement length, capped at 8, in place of n on a match)
//   one byte a cycle while rsp is not stalled, via the state and output registers;
//   any other byte is registered and appears in the cycle after acceptance
// reset clears the word count, passthrough flag and output valid and loads the
// default configuration; a stalled rsp holds the output register and req_stall
// rises until the output register is free again
module whole_word_substituter_unit
   import wws_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_char_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAR_W-1:0]    rsp_char_out,
   output logic                 rsp_from_replacement,
   output logic                 rsp_run_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   wws_cmd_type    cmd;
   wws_status_type status;

   wws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wws_datapath #(
      .MAX_WORD (MAX_WORD)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_char_in          (req_char_in),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_char_out         (rsp_char_out),
      .rsp_from_replacement (rsp_from_replacement),
      .rsp_run_end          (rsp_run_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

>>> rtl/core/wws_checker.sv
// wws_checker: port-level assertions for whole_word_substituter_unit
// depends on wws_pkg; attached to the top level by the bind below
module wws_checker
   import wws_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_char_out,
   input logic              rsp_from_replacement,
   input logic              rsp_run_end
);

   // stalled result byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_run_end)))
      else $error("stalled result word changed");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a replacement byte is never the last of a run
   a_rep_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_from_replacement) |-> !rsp_run_end)
      else $error("replacement byte flagged as run end");

   // input only taken when the output register can take a result
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("input accepted while output register blocked");

endmodule

bind whole_word_substituter_unit wws_checker u_wws_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_char_out         (rsp_char_out),
   .rsp_from_replacement (rsp_from_replacement),
   .rsp_run_end          (rsp_run_end)
);

>>> verif/whole_word_substituter_unit_tb.sv
// whole_word_substituter_unit_tb: self-checking bench for the whole-word substituter
// predicts every output byte from the accepted text and the csr settings, checks in order
// depends on wws_pkg and whole_word_substituter_unit
module whole_word_substituter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wws_pkg::*;

   localparam int WORD_SLOTS = MAX_WORD_DEFAULT;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_WORDS = 10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_GRAVE = 8'h60;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              rep;
      logic              last;
   } text_byte_type;

   class word_substitution_checker;
      logic [WORD_W-1:0] target_word;
      logic [LEN_W-1:0]  target_len;
      logic [WORD_W-1:0] replacement_word;
      logic [LEN_W-1:0]  replacement_len;
      logic [CHAR_W-1:0] letters [WORD_SLOTS];
      int unsigned       letter_count;
      bit                passing;
      text_byte_type     pending_text [$];
      int unsigned       errors;
      int unsigned       chars_in;
      int unsigned       chars_checked;
      int unsigned       replacements;

      function new();
         target_word = '0;
         target_len = 4'd1;
         replacement_word = '0;
         replacement_len = 4'd1;
         letter_count = 0;
         passing = 1'b0;
         errors = 0;
         chars_in = 0;
         chars_checked = 0;
         replacements = 0;
      endfunction

      static function bit is_alpha(logic [CHAR_W-1:0] c);
         return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_TARGET_WORD: target_word = data;
            CSR_TARGET_LENGTH: target_len = data[LEN_W-1:0];
            CSR_REPLACEMENT_WORD: replacement_word = data;
            CSR_REPLACEMENT_LENGTH: replacement_len = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      function void take_char(logic [CHAR_W-1:0] c);
         text_byte_type run [$];
         bit hit;
         int unsigned n;
         chars_in++;
         if (is_alpha(c)) begin
            if (passing) begin
               run.push_back(text_byte_type'{c, 1'b0, 1'b0});
            end else if (letter_count < WORD_SLOTS) begin
               letters[letter_count] = c;
               letter_count++;
            end else begin
               for (int i = 0; i < letter_count; i++)
                  run.push_back(text_byte_type'{letters[i], 1'b0, 1'b0});
               run.push_back(text_byte_type'{c, 1'b0, 1'b0});
               letter_count = 0;
               passing = 1'b1;
            end
         end else begin
            if (passing) begin
               passing = 1'b0;
            end else if (letter_count > 0) begin
               hit = (letter_count == target_len);
               for (int i = 0; i < letter_count; i++)
                  if (letters[i] != target_word[8*i +: 8]) hit = 1'b0;
               if (hit) begin
                  n = (replacement_len > REP_MAX) ? REP_MAX : replacement_len;
                  for (int i = 0; i < n; i++)
                     run.push_back(text_byte_type'{replacement_word[8*i +: 8], 1'b1, 1'b0});
                  replacements++;
               end else begin
                  for (int i = 0; i < letter_count; i++)
                     run.push_back(text_byte_type'{letters[i], 1'b0, 1'b0});
               end
            end
            letter_count = 0;
            run.push_back(text_byte_type'{c, 1'b0, 1'b0});
         end
         if (run.size() > 0) begin
            run[run.size()-1].last = 1'b1;
            foreach (run[i]) pending_text.push_back(run[i]);
         end
      endfunction

      function void check_char(text_byte_type got);
         text_byte_type want;
         chars_checked++;
         if (pending_text.size() == 0) begin
            flag($sformatf("unexpected byte %h rep %b end %b", got.ch, got.rep, got.last));
            return;
         end
         want = pending_text.pop_front();
         if (got.ch !== want.ch || got.rep !== want.rep || got.last !== want.last)
            flag($sformatf("char %h/%h rep %b/%b end %b/%b (expected/actual)",
                           want.ch, got.ch, want.rep, got.rep, want.last, got.last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_char_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CHAR_W-1:0]    rsp_char_out;
   logic                 rsp_from_replacement;
   logic                 rsp_run_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;

   word_substitution_checker sb;
   bit                send_gaps;
   bit                rsp_gaps;
   bit                hold_req;
   logic [WORD_W-1:0] tgt_word_v;
   int                tgt_n;
   int                settings_used;

   whole_word_substituter_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_from_replacement(rsp_from_replacement),
      .rsp_run_end(rsp_run_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [CHAR_W-1:0] rand_letter();
      return $urandom_range(0, 1) ? CHAR_W'(CHAR_UPPER_A + $urandom_range(0, 25))
                                  : CHAR_W'(CHAR_LOWER_A + $urandom_range(0, 25));
   endfunction

   function automatic logic [CHAR_W-1:0] rand_other();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255));
      while (word_substitution_checker::is_alpha(c));
      return c;
   endfunction

   task automatic send_char(logic [CHAR_W-1:0] c);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (req_stall);
      sb.take_char(c);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   // one word-like chunk followed by a separator
   task automatic send_chunk();
      logic [CHAR_W-1:0] word_q [$];
      int pick;
      int n;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 60 && tgt_n > 0) begin
         for (k = 0; k < tgt_n; k++) word_q.push_back(tgt_word_v[8*k +: 8]);
         if (pick >= 35 && pick < 45) begin
            k = $urandom_range(0, tgt_n - 1);
            word_q[k] = word_q[k] ^ 8'h20;
         end else if (pick >= 45 && pick < 52) begin
            word_q.push_back(rand_letter());
         end else if (pick >= 52 && tgt_n > 1) begin
            void'(word_q.pop_back());
         end
      end else if (pick < 90) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         repeat (n) word_q.push_back(rand_letter());
      end else begin
         word_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      foreach (word_q[i]) send_char(word_q[i]);
      pick = $urandom_range(0, 9);
      if (pick < 4) send_char(CHAR_SPACE);
      else if (pick < 6) send_char(CHAR_NEWLINE);
      else send_char(rand_other());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_text.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic set_config(logic [WORD_W-1:0] tw, logic [LEN_W-1:0] tl,
                             logic [WORD_W-1:0] rw, logic [LEN_W-1:0] rl,
                             logic [CSR_IDX_W-1:0] spare_idx);
      write_reg(CSR_TARGET_WORD, tw);
      write_reg(CSR_TARGET_LENGTH, {{(WORD_W-LEN_W){1'b0}}, tl});
      write_reg(CSR_REPLACEMENT_WORD, rw);
      write_reg(spare_idx, {$urandom, $urandom});
      write_reg(CSR_REPLACEMENT_LENGTH, {$urandom, $urandom} << LEN_W | rl);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic make_target(int n);
      tgt_word_v = {$urandom, $urandom};
      for (int i = 0; i < n; i++) tgt_word_v[8*i +: 8] = rand_letter();
      tgt_n = n;
   endtask

   task automatic run_phase();
      int unsigned start;
      start = sb.chars_in;
      while (sb.chars_in - start < PHASE_WORDS) send_chunk();
      wait_drained();
   endtask

   // receiver side: random stall bursts and one long hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_req = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char(text_byte_type'{rsp_char_out, rsp_from_replacement, rsp_run_end});
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL whole_word_substituter_unit");
      $finish;
   end

   initial begin
      sb = new();
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      hold_req = 1'b0;
      tgt_n = 0;
      settings_used = 1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_in <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings: field extremes and letter range edges
      send_char(8'h00);
      send_char(8'hff);
      send_text("Az@[");
      send_char(CHAR_GRAVE);
      send_text("{\n");
      wait_drained();

      // match, case mismatch, longer word, over-long word with passthrough
      set_config(64'h0000_0000_0074_6163, 4'd3, 64'h0000_0000_7367_6f64, 4'd4, 8'd4);
      send_text("cat Cats abcdefghiX\n");
      wait_drained();

      make_target($urandom_range(2, 5));
      set_config(tgt_word_v, tgt_n[LEN_W-1:0], {$urandom, $urandom}, 4'd15, 8'd255);
      run_phase();

      make_target(WORD_SLOTS);
      set_config(tgt_word_v, 4'd8, 64'h0, 4'd0, CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      tgt_n = 0;
      set_config(64'h0, 4'd0, {WORD_W{1'b1}}, 4'd8, CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      make_target(1);
      set_config(tgt_word_v, 4'd1, {$urandom, $urandom}, 4'd1,
                 CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      make_target(WORD_SLOTS);
      set_config({WORD_W{1'b1}}, 4'd15, {$urandom, $urandom}, LEN_W'($urandom_range(1, 8)),
                 CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      make_target($urandom_range(1, 8));
      set_config(tgt_word_v, tgt_n[LEN_W-1:0], {$urandom, $urandom},
                 LEN_W'($urandom_range(1, 8)), CSR_IDX_W'($urandom_range(4, 255)));
      hold_req = 1'b1;
      run_phase();

      make_target($urandom_range(1, 8));
      set_config(tgt_word_v, LEN_W'($urandom_range(8, 9)), {$urandom, $urandom},
                 LEN_W'($urandom_range(9, 15)), CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      // closing stretch at full rate on both sides
      send_gaps = 1'b0;
      rsp_gaps = 1'b0;
      make_target($urandom_range(1, 8));
      set_config(tgt_word_v, tgt_n[LEN_W-1:0], {$urandom, $urandom},
                 LEN_W'($urandom_range(0, 15)), CSR_IDX_W'($urandom_range(4, 255)));
      run_phase();

      repeat (2 * TAIL_CYCLES) @(posedge clock);
      if (sb.pending_text.size() != 0)
         sb.flag($sformatf("%0d expected bytes never arrived", sb.pending_text.size()));

      $display("covered %0d input bytes and %0d output bytes over %0d settings",
               sb.chars_in, sb.chars_checked, settings_used);
      $display("%0d words replaced, %0d mismatches", sb.replacements, sb.errors);
      if (sb.errors == 0)
         $display("PASS whole_word_substituter_unit");
      else
         $display("FAIL whole_word_substituter_unit");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/wws_pkg.sv
rtl/core/wws_ctrl.sv
rtl/core/wws_datapath.sv
rtl/core/whole_word_substituter_unit.sv
rtl/core/wws_checker.sv
verif/whole_word_substituter_unit_tb.sv
